// File: rtl/phd_pkg.sv
// Package for the perfect / harmonic-divisor classifier.
// Widths, sequencer states, divider handshake structs and the result struct; no dependencies.
`default_nettype none
package phd_pkg;

   localparam int NUMBER_WIDTH = 16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int COUNT_OUT_W = 8;
   localparam int SUM_OUT_W = 18;

   localparam int I_W = (NUMBER_WIDTH + 1) / 2 + 1;
   localparam int CNT_W = (NUMBER_WIDTH + 1) / 2 + 2;
   localparam int SIG_W = NUMBER_WIDTH + 4;
   localparam int DVD_W = NUMBER_WIDTH + CNT_W;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   localparam logic [63:0] COUNT_MAX = 64'd255;
   localparam logic [63:0] SUM_MAX = 64'd262143;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRIAL,
      ST_HARM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [SIG_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DVD_W-1:0]  quotient;
      logic [SIG_W-1:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                   is_harmonic;
      logic                   is_perfect;
      logic [SUM_OUT_W-1:0]   proper_divisor_sum;
      logic [COUNT_OUT_W-1:0] divisor_count;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/phd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses phd_pkg for widths and the request/response structs.
`default_nettype none
module phd_div
   import phd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [SIG_W-1:0]  rem_ff, rem_in;
   logic [SIG_W-1:0]  dsr_ff, dsr_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIG_W:0]    trial;
   logic              fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      fits = trial >= {1'b0, dsr_ff};
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         dsr_in = div_req.divisor;
         rem_in = '0;
         cnt_in = DCNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? SIG_W'(trial - {1'b0, dsr_ff}) : trial[SIG_W-1:0];
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = dvd_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

// File: rtl/phd_seq.sv
// Trial-division sequencer: walks divisors up to sqrt(n), then runs the harmonic test.
// Uses phd_pkg; drives the shared phd_div unit.
`default_nettype none
module phd_seq
   import phd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic [REQ_DATA_W-1:0]  in_number,
   output logic                        in_ready,
   output logic                        res_valid,
   input  wire logic                   res_ready,
   output result_type                  res,
   output div_req_type                 div_req,
   input  wire div_rsp_type            div_rsp
);

   state_type             state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] n_ff, n_in, n_new;
   logic [I_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SIG_W-1:0]      sig_ff, sig_in;
   logic                  harm_ff, harm_in;
   logic [DVD_W-1:0]      prod;
   logic [SIG_W-1:0]      proper;

   assign n_new = NUMBER_WIDTH'(in_number);
   assign prod = {{CNT_W{1'b0}}, n_ff} * {{NUMBER_WIDTH{1'b0}}, cnt_ff};

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;
      cnt_in = cnt_ff;
      sig_in = sig_ff;
      harm_in = harm_ff;
      in_ready = 1'b0;
      res_valid = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = DVD_W'(n_ff);
      div_req.divisor = SIG_W'(i_ff);
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               n_in = n_new;
               i_in = I_W'(1);
               cnt_in = '0;
               sig_in = '0;
               harm_in = 1'b0;
               if (n_new == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  div_req.start = 1'b1;
                  div_req.dividend = DVD_W'(n_new);
                  div_req.divisor = SIG_W'(1);
                  state_in = ST_TRIAL;
               end
            end
         end
         ST_TRIAL: begin
            if (div_rsp.done) begin
               if (DVD_W'(i_ff) > div_rsp.quotient) begin
                  div_req.start = 1'b1;
                  div_req.dividend = prod;
                  div_req.divisor = sig_ff;
                  state_in = ST_HARM;
               end else begin
                  if (div_rsp.remainder == '0) begin
                     if (div_rsp.quotient == DVD_W'(i_ff)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                        sig_in = sig_ff + SIG_W'(i_ff);
                     end else begin
                        cnt_in = cnt_ff + CNT_W'(2);
                        sig_in = sig_ff + SIG_W'(i_ff) + SIG_W'(div_rsp.quotient);
                     end
                  end
                  i_in = i_ff + I_W'(1);
                  div_req.start = 1'b1;
                  div_req.dividend = DVD_W'(n_ff);
                  div_req.divisor = SIG_W'(i_in);
               end
            end
         end
         ST_HARM: begin
            if (div_rsp.done) begin
               harm_in = div_rsp.remainder == '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      cnt_ff <= cnt_in;
      sig_ff <= sig_in;
      harm_ff <= harm_in;
   end

   always_comb begin
      proper = sig_ff - SIG_W'(n_ff);
      res.divisor_count = (64'(cnt_ff) > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX)
                                                    : COUNT_OUT_W'(cnt_ff);
      res.proper_divisor_sum = (64'(proper) > SUM_MAX) ? SUM_OUT_W'(SUM_MAX)
                                                       : SUM_OUT_W'(proper);
      res.is_perfect = (n_ff > NUMBER_WIDTH'(1)) && (proper == SIG_W'(n_ff));
      res.is_harmonic = harm_ff;
   end

endmodule
`default_nettype wire

// File: rtl/perfect_harmonic_divisor_classifier.sv
// Top level of the perfect / harmonic-divisor classifier.
// Uses phd_pkg; instantiates phd_seq and phd_div and holds the result register.
//
// Usage:
//   req channel: one beat carries the number in req_tdata[15:0]. req_tready is high
//   only while the sequencer is idle; one number is worked on at a time.
//   rsp channel: one beat per number: divisor count, proper divisor sum, perfect flag
//   and harmonic flag.
// Operation:
//   Each trial division runs in the shared bit-serial divider. Divisors are tried
//   from 1 up to floor(sqrt(n)) + 1, then one more division does the harmonic test.
//   Zero skips the divider and goes straight to the result.
// Reset: synchronous, clears the sequencer state and the result valid flag; no pending beat.
// Stall: a finished result sits in the output register until rsp_tready; the next
//   number is taken meanwhile, and its result waits in the sequencer if the
//   register is still full.
`default_nettype none
module perfect_harmonic_divisor_classifier
   import phd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // [15:0] number
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata   // [7:0] divisor_count,
                                                   // [25:8] proper_divisor_sum,
                                                   // [26] is_perfect, [27] is_harmonic
);

   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  res;
   logic        res_valid;
   logic        res_ready;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   result_type  rsp_data_ff, rsp_data_in;

   phd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_number (req_tdata),
      .in_ready  (req_tready),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   phd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in = res;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_data_ff);

endmodule
`default_nettype wire

// File: rtl/phd_checker.sv
// Port-level checks for the perfect / harmonic-divisor classifier.
// Uses phd_pkg widths; bound to the top level at the end of this file.
`default_nettype none
module phd_checker
   import phd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a number is in work");

   a_perfect_is_harmonic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[27] && (rsp_tdata[7:0] != 8'd0))
      else $error("perfect number not flagged harmonic");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:28] == '0)
      else $error("rsp pad bits set");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind perfect_harmonic_divisor_classifier phd_checker u_phd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: sim/tb_perfect_harmonic_divisor_classifier.sv
// Testbench for perfect_harmonic_divisor_classifier: drives numbers on the req stream,
// predicts divisor count, proper sum, perfect and harmonic flags, checks the rsp stream.
// Depends on phd_pkg and the classifier RTL only.
module tb_perfect_harmonic_divisor_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import phd_pkg::*;

   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 60;

   localparam logic [REQ_DATA_W-1:0] NOTABLE_NUMBERS [25] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd12, 16'd28, 16'd140, 16'd270,
      16'd496, 16'd672, 16'd1638, 16'd2970, 16'd8128, 16'd8190, 16'd30240,
      16'd32760, 16'd32768, 16'd45360, 16'd55440, 16'd55860, 16'd65521,
      16'd65534, 16'd65535
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   result_type pending_results[$];
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rsp_hold_left = 0;
   int error_count = 0;
   int numbers_sent = 0;
   int results_checked = 0;
   int perfect_seen = 0;
   int harmonic_seen = 0;

   perfect_harmonic_divisor_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_perfect_harmonic_divisor_classifier: done, errors");
      $finish;
   end

   function automatic result_type classify_number(input logic [REQ_DATA_W-1:0] raw);
      longint unsigned n;
      longint unsigned cnt;
      longint unsigned sigma;
      longint unsigned proper;
      longint unsigned i;
      longint unsigned j;
      result_type r;
      n = longint'(raw) & ((64'd1 << NUMBER_WIDTH) - 1);
      cnt = 0;
      sigma = 0;
      for (i = 1; n != 0 && i <= n / i; i++) begin
         if (n % i == 0) begin
            j = n / i;
            cnt++;
            sigma += i;
            if (j != i) begin
               cnt++;
               sigma += j;
            end
         end
      end
      proper = (n == 0) ? 0 : sigma - n;
      r.divisor_count = (cnt > COUNT_MAX) ? COUNT_MAX[COUNT_OUT_W-1:0]
                                          : cnt[COUNT_OUT_W-1:0];
      r.proper_divisor_sum = (proper > SUM_MAX) ? SUM_MAX[SUM_OUT_W-1:0]
                                                : proper[SUM_OUT_W-1:0];
      r.is_perfect = (n > 1) && (proper == n);
      r.is_harmonic = (n > 0) && (sigma != 0) && ((n * cnt) % sigma == 0);
      return r;
   endfunction

   task automatic send_number(input logic [REQ_DATA_W-1:0] n);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= n;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(classify_number(n));
      numbers_sent++;
   endtask

   function automatic logic [REQ_DATA_W-1:0] pick_number();
      int r;
      r = $urandom_range(99);
      if (r < 12)
         return REQ_DATA_W'($urandom_range(65535));
      else if (r < 30)
         return NOTABLE_NUMBERS[$urandom_range(24)];
      else if (r < 40)
         return REQ_DATA_W'($urandom_range(15));
      else
         return REQ_DATA_W'($urandom_range(1023));
   endfunction

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            perfect_seen += want.is_perfect;
            harmonic_seen += want.is_harmonic;
            if (got.divisor_count !== want.divisor_count) begin
               $display("%0t: divisor_count expected %0d actual %0d",
                        $time, want.divisor_count, got.divisor_count);
               error_count++;
            end
            if (got.proper_divisor_sum !== want.proper_divisor_sum) begin
               $display("%0t: proper_divisor_sum expected %0d actual %0d",
                        $time, want.proper_divisor_sum, got.proper_divisor_sum);
               error_count++;
            end
            if (got.is_perfect !== want.is_perfect) begin
               $display("%0t: is_perfect expected %0b actual %0b",
                        $time, want.is_perfect, got.is_perfect);
               error_count++;
            end
            if (got.is_harmonic !== want.is_harmonic) begin
               $display("%0t: is_harmonic expected %0b actual %0b",
                        $time, want.is_harmonic, got.is_harmonic);
               error_count++;
            end
         end
      end
   end

   task automatic test_notable_numbers();
      tx_idle_pct = 13;
      rx_idle_pct = 47;
      foreach (NOTABLE_NUMBERS[k])
         send_number(NOTABLE_NUMBERS[k]);
   endtask

   task automatic test_random_numbers(input int count, input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (count)
         send_number(pick_number());
   endtask

   task automatic test_output_stall();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (6)
         send_number(REQ_DATA_W'($urandom_range(63)));
   endtask

   initial begin : run_tests
      int waited;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_notable_numbers();
      test_random_numbers(25, 13, 47);
      test_random_numbers(25, 47, 13);
      test_output_stall();
      test_random_numbers(19, 0, 0);
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d numbers (notable values, random values, an output stall)",
               numbers_sent);
      $display("checked %0d results, %0d perfect and %0d harmonic among them",
               results_checked, perfect_seen, harmonic_seen);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_perfect_harmonic_divisor_classifier: done, clean");
      end else begin
         $display("tb_perfect_harmonic_divisor_classifier: done, errors");
      end
      $finish;
   end

endmodule

// File: perfect_harmonic_divisor_classifier.f
rtl/phd_pkg.sv
rtl/phd_div.sv
rtl/phd_seq.sv
rtl/perfect_harmonic_divisor_classifier.sv
rtl/phd_checker.sv
sim/tb_perfect_harmonic_divisor_classifier.sv
